### design/mqlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqlf_pkg
// Shared types for the multi-queue linked FIFO: opcodes, status codes, FSM.
// ----------------------------------------------------------------------------
package mqlf_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP        = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

endpackage

### design/mqlf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqlf_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mqlf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/multi_queue_linked_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_linked_fifo_unit
// Several queues sharing one linked node store with a free list.
// Result word: the input word is registered on accept, and the result word is
//   registered when the execute state can hand it on. One word in flight at a
//   time; the node link RAM is read in the accept cycle and written back in the execute state.
// Reset: pointers, counts and handshake state clear synchronously; the initial
//   free chain comes from a fresh-node counter, so no RAM clearing pass.
// ----------------------------------------------------------------------------
module multi_queue_linked_fifo_unit #(
  parameter int NODE_DEPTH  = 64,
  parameter int WORD_WIDTH  = 32,
  parameter int QUEUE_COUNT = 4,
  localparam int PTR_W  = $clog2(NODE_DEPTH),
  localparam int CNT_W  = $clog2(NODE_DEPTH + 1),
  localparam int IN_W   = ((WORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W  = ((WORD_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // push_word
  input  logic [3:0]       s_tuser,   // opcode, queue_id
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // pop_word, queue_occupancy
  output logic [2:0]       m_tuser    // pop_valid, status
);

  localparam int QI_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  mqlf_pkg::fsm_t state, state_next;

  logic [PTR_W-1:0] free_head, free_head_next;
  logic [CNT_W-1:0] free_count, free_count_next;
  logic [CNT_W-1:0] fresh, fresh_next;
  logic [PTR_W-1:0] q_head [QUEUE_COUNT];
  logic [PTR_W-1:0] q_tail [QUEUE_COUNT];
  logic [CNT_W-1:0] q_size [QUEUE_COUNT];

  mqlf_pkg::op_t     op_r;
  logic [QI_W-1:0]   qi_r;
  logic              q_ok_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [PTR_W-1:0]  cur_head, cur_tail, rd_addr_r;
  logic [CNT_W-1:0]  cur_size;

  logic [PTR_W-1:0] head_next, tail_next;
  logic [CNT_W-1:0] size_next;

  logic              accept, exec_go;
  mqlf_pkg::op_t     in_op;
  logic [QI_W-1:0]   in_qi;
  logic [PTR_W-1:0]  rd_addr;

  logic              link_we, word_we;
  logic [PTR_W-1:0]  link_waddr;
  logic [PTR_W-1:0]  link_wdata, link_rd, link_eff;
  logic [WORD_WIDTH-1:0] word_rd;

  logic [WORD_WIDTH-1:0] pop_word;
  logic              pop_valid;
  mqlf_pkg::stat_t   status;
  logic [CNT_W-1:0]  occ;

  assign in_op  = mqlf_pkg::op_t'(s_tuser[1:0]);
  assign in_qi  = QI_W'(s_tuser[3:2]);
  assign accept = s_tvalid && s_tready;
  assign rd_addr = (in_op == mqlf_pkg::OP_PUSH_REAR || in_op == mqlf_pkg::OP_PUSH_FRONT)
                   ? free_head : q_head[in_qi];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mqlf_pkg::FSM_IDLE: if (accept) state_next = mqlf_pkg::FSM_EXEC;
      mqlf_pkg::FSM_EXEC: if (exec_go) state_next = mqlf_pkg::FSM_IDLE;
      default:            state_next = mqlf_pkg::FSM_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready = 1'b0;
    exec_go  = 1'b0;
    case (state)
      mqlf_pkg::FSM_IDLE: s_tready = 1'b1;
      mqlf_pkg::FSM_EXEC: exec_go  = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
        exec_go  = 1'b0;
      end
    endcase
  end

  // untouched nodes (index at or above fresh) read as the initial chain i -> i+1
  always_comb begin
    if (CNT_W'(rd_addr_r) >= fresh) begin
      link_eff = (rd_addr_r == PTR_W'(NODE_DEPTH - 1)) ? '0 : rd_addr_r + 1'b1;
    end else begin
      link_eff = link_rd;
    end
  end

  always_comb begin
    free_head_next  = free_head;
    free_count_next = free_count;
    fresh_next      = fresh;
    head_next       = cur_head;
    tail_next       = cur_tail;
    size_next       = cur_size;
    link_we         = 1'b0;
    link_waddr      = cur_tail;
    link_wdata      = free_head;
    word_we         = 1'b0;
    pop_word        = '0;
    pop_valid       = 1'b0;
    status          = mqlf_pkg::STAT_OK;
    if (q_ok_r) begin
      case (op_r)
        mqlf_pkg::OP_PUSH_REAR, mqlf_pkg::OP_PUSH_FRONT: begin
          if (free_count == '0) begin
            status = mqlf_pkg::STAT_FULL;
          end else begin
            word_we         = 1'b1;
            free_head_next  = link_eff;
            free_count_next = free_count - 1'b1;
            if (CNT_W'(free_head) == fresh) fresh_next = fresh + 1'b1;
            size_next = cur_size + 1'b1;
            if (cur_size == '0) begin
              head_next = free_head;
              tail_next = free_head;
            end else if (op_r == mqlf_pkg::OP_PUSH_REAR) begin
              link_we    = 1'b1;
              link_waddr = cur_tail;
              link_wdata = free_head;
              tail_next  = free_head;
            end else begin
              link_we    = 1'b1;
              link_waddr = free_head;
              link_wdata = cur_head;
              head_next  = free_head;
            end
          end
        end
        mqlf_pkg::OP_POP: begin
          if (cur_size == '0) begin
            status    = mqlf_pkg::STAT_EMPTY;
            head_next = '0;
            tail_next = '0;
            size_next = '0;
          end else begin
            pop_word        = word_rd;
            pop_valid       = 1'b1;
            size_next       = cur_size - 1'b1;
            head_next       = link_eff;
            if (cur_size == CNT_W'(1)) begin
              head_next = '0;
              tail_next = '0;
            end
            link_we         = 1'b1;
            link_waddr      = cur_head;
            link_wdata      = free_head;
            free_head_next  = cur_head;
            free_count_next = free_count + 1'b1;
          end
        end
        default: begin
          if (cur_size != '0) begin
            link_we         = 1'b1;
            link_waddr      = cur_tail;
            link_wdata      = free_head;
            free_head_next  = cur_head;
            free_count_next = free_count + cur_size;
          end
          head_next = '0;
          tail_next = '0;
          size_next = '0;
        end
      endcase
    end
    occ = q_ok_r ? size_next : '0;
  end

  mqlf_ram #(.WIDTH(PTR_W), .DEPTH(NODE_DEPTH)) u_link_ram (
    .clk     (clk),
    .wr_en   (exec_go && link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (link_rd)
  );

  mqlf_ram #(.WIDTH(WORD_WIDTH), .DEPTH(NODE_DEPTH)) u_word_ram (
    .clk     (clk),
    .wr_en   (exec_go && word_we),
    .wr_addr (free_head),
    .wr_data (word_r),
    .rd_en   (accept),
    .rd_addr (q_head[in_qi]),
    .rd_data (word_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      qi_r      <= in_qi;
      word_r    <= s_tdata[WORD_WIDTH-1:0];
      cur_head  <= q_head[in_qi];
      cur_tail  <= q_tail[in_qi];
      cur_size  <= q_size[in_qi];
      rd_addr_r <= rd_addr;
    end
    if (exec_go) begin
      m_tdata <= OUT_W'({occ, pop_word});
      m_tuser <= {status, pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mqlf_pkg::FSM_IDLE;
      m_tvalid   <= 1'b0;
      q_ok_r     <= 1'b0;
      free_head  <= '0;
      free_count <= CNT_W'(NODE_DEPTH);
      fresh      <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        q_head[i] <= '0;
        q_tail[i] <= '0;
        q_size[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        q_ok_r <= int'(s_tuser[3:2]) < QUEUE_COUNT;
      end
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (exec_go && q_ok_r) begin
        free_head    <= free_head_next;
        free_count   <= free_count_next;
        fresh        <= fresh_next;
        q_head[qi_r] <= head_next;
        q_tail[qi_r] <= tail_next;
        q_size[qi_r] <= size_next;
      end
    end
  end

endmodule

### design/mqlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqlf_checker
// Port-level checks for the multi-queue linked FIFO.
// ----------------------------------------------------------------------------
module mqlf_checker #(
  parameter int NODE_DEPTH = 64,
  parameter int WORD_WIDTH = 32,
  localparam int CNT_W = $clog2(NODE_DEPTH + 1),
  localparam int OUT_W = ((WORD_WIDTH + CNT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [2:0]       m_tuser
);

  logic [WORD_WIDTH-1:0] pop_word;
  logic [CNT_W-1:0]      occ;
  logic [1:0]            status;

  assign pop_word = m_tdata[WORD_WIDTH-1:0];
  assign occ      = m_tdata[WORD_WIDTH+CNT_W-1:WORD_WIDTH];
  assign status   = m_tuser[2:1];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in flight");

  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> status == mqlf_pkg::STAT_OK)
    else $error("popped word with non-ok status");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == mqlf_pkg::STAT_EMPTY |-> occ == '0 && pop_word == '0)
    else $error("empty pop reported data or occupancy");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> int'(occ) <= NODE_DEPTH && status != 2'd3)
    else $error("occupancy or status out of range");

endmodule

bind multi_queue_linked_fifo_unit mqlf_checker #(
  .NODE_DEPTH (NODE_DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_mqlf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### bench/multi_queue_linked_fifo_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_linked_fifo_unit_test
// Self-checking bench for the shared-store multi-queue FIFO. A directed run
// covers each operation, the word extremes, pops and clears of empty queues
// and front pushes into empty queues. Random bursts then fill the store past
// full, drain queues past empty and mix clears in, with random gaps on the
// input and random back-pressure on the output. Each result word is checked
// against a linked-list predictor kept inside the bench.
// ----------------------------------------------------------------------------
module multi_queue_linked_fifo_unit_test;

  localparam int NODES       = 64;
  localparam int QUEUES      = 4;
  localparam int RANDOM_OPS  = 1450;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    mqlf_pkg::op_t op;
    logic [1:0]    qid;
    logic [31:0]   word;
    logic          quiet;
  } request_t;

  typedef struct {
    logic [31:0]     word;
    logic            valid;
    mqlf_pkg::stat_t status;
    logic [6:0]      occ;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // push_word
  logic [3:0]  s_tuser = '0;   // opcode, queue_id
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // pop_word, queue_occupancy
  logic [2:0]  m_tuser;        // pop_valid, status

  multi_queue_linked_fifo_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // linked-list mirror of the node store
  logic [31:0] node_data [NODES];
  logic [5:0]  node_next [NODES];
  logic [5:0]  free_ptr;
  logic [6:0]  free_nodes;
  logic [5:0]  head_ptr  [QUEUES];
  logic [5:0]  tail_ptr  [QUEUES];
  logic [6:0]  depth     [QUEUES];

  request_t op_backlog[$];
  reply_t   awaited_replies[$];
  request_t current_op;
  int       idle_left  = 0;
  int       stall_left = 0;
  logic     quiet      = 1'b0;
  int       mismatches = 0;
  int       cycles     = 0;

  function automatic reply_t apply_queue_op(request_t r);
    reply_t     res;
    logic [5:0] n;
    int         q;
    q          = int'(r.qid);
    res.word   = '0;
    res.valid  = 1'b0;
    res.status = mqlf_pkg::STAT_OK;
    case (r.op)
      mqlf_pkg::OP_PUSH_REAR, mqlf_pkg::OP_PUSH_FRONT: begin
        if (free_nodes == '0) begin
          res.status = mqlf_pkg::STAT_FULL;
        end else begin
          n            = free_ptr;
          free_ptr     = node_next[n];
          free_nodes   = free_nodes - 7'd1;
          node_data[n] = r.word;
          if (depth[q] == '0) begin
            node_next[n] = '0;
            head_ptr[q]  = n;
            tail_ptr[q]  = n;
          end else if (r.op == mqlf_pkg::OP_PUSH_REAR) begin
            node_next[tail_ptr[q]] = n;
            node_next[n]           = '0;
            tail_ptr[q]            = n;
          end else begin
            node_next[n] = head_ptr[q];
            head_ptr[q]  = n;
          end
          depth[q] = depth[q] + 7'd1;
        end
      end
      mqlf_pkg::OP_POP: begin
        if (depth[q] == '0) begin
          head_ptr[q] = '0;
          tail_ptr[q] = '0;
          res.status  = mqlf_pkg::STAT_EMPTY;
        end else begin
          n           = head_ptr[q];
          res.word    = node_data[n];
          res.valid   = 1'b1;
          head_ptr[q] = node_next[n];
          depth[q]    = depth[q] - 7'd1;
          if (depth[q] == '0) begin
            head_ptr[q] = '0;
            tail_ptr[q] = '0;
          end
          node_next[n] = free_ptr;
          free_ptr     = n;
          free_nodes   = free_nodes + 7'd1;
        end
      end
      default: begin
        if (depth[q] != '0) begin
          node_next[tail_ptr[q]] = free_ptr;
          free_ptr               = head_ptr[q];
          free_nodes             = free_nodes + depth[q];
        end
        head_ptr[q] = '0;
        tail_ptr[q] = '0;
        depth[q]    = '0;
      end
    endcase
    res.occ = depth[q];
    return res;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic queue_op(mqlf_pkg::op_t op, int qid, logic [31:0] word, logic calm);
    request_t r;
    r.op    = op;
    r.qid   = qid[1:0];
    r.word  = word;
    r.quiet = calm;
    op_backlog.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_replies.push_back(apply_queue_op(current_op));
        void'(op_backlog.pop_front());
        idle_left = current_op.quiet ? 0 : pick_pause();
      end
      if (s_tvalid && !s_tready) begin
        // hold the word until taken
      end else if (idle_left > 0) begin
        idle_left--;
        s_tvalid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        current_op = op_backlog[0];
        quiet      <= current_op.quiet;
        s_tvalid   <= 1'b1;
        s_tdata    <= current_op.word;
        s_tuser    <= {current_op.qid, current_op.op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected result word %0h / %0h", m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (m_tdata[31:0] !== want.word) begin
            $error("pop_word: expected %0h, got %0h", want.word, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tuser[0] !== want.valid) begin
            $error("pop_valid: expected %0h, got %0h", want.valid, m_tuser[0]);
            mismatches++;
          end
          if (m_tuser[2:1] !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, m_tuser[2:1]);
            mismatches++;
          end
          if (m_tdata[38:32] !== want.occ) begin
            $error("queue_occupancy: expected %0h, got %0h", want.occ, m_tdata[38:32]);
            mismatches++;
          end
        end
      end
      if (quiet) begin
        stall_left = 0;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = pick_pause();
        m_tready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int            issued;
    int            len;
    int            mode;
    int            fav;
    int            q;
    int            r;
    logic          calm;
    mqlf_pkg::op_t push_op;
    for (int i = 0; i < NODES; i++) begin
      node_data[i] = '0;
      node_next[i] = 6'(i + 1);
    end
    free_ptr   = '0;
    free_nodes = 7'(NODES);
    for (int i = 0; i < QUEUES; i++) begin
      head_ptr[i] = '0;
      tail_ptr[i] = '0;
      depth[i]    = '0;
    end

    queue_op(mqlf_pkg::OP_POP,        0, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_CLEAR,      1, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  0, 32'h0000_0000, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  0, 32'hFFFF_FFFF, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_FRONT, 0, 32'hA5A5_A5A5, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_FRONT, 1, 32'h5A5A_5A5A, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  1, 32'h1234_5678, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  2, 32'h8000_0001, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_FRONT, 3, 32'h7FFF_FFFE, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  3, 32'hFFFF_FFFF, 1'b0);
    queue_op(mqlf_pkg::OP_POP,        0, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_POP,        1, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_CLEAR,      0, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_POP,        0, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_POP,        1, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_POP,        1, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  1, 32'hDEAD_BEEF, 1'b0);
    queue_op(mqlf_pkg::OP_PUSH_FRONT, 1, 32'h0000_0001, 1'b0);
    queue_op(mqlf_pkg::OP_POP,        2, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_POP,        3, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_CLEAR,      3, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_CLEAR,      1, 32'h0,         1'b0);
    queue_op(mqlf_pkg::OP_PUSH_REAR,  2, 32'h0000_FFFF, 1'b0);
    queue_op(mqlf_pkg::OP_POP,        2, 32'h0,         1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // hold the sender until every directed result is back
    while (op_backlog.size() > 0 || awaited_replies.size() > 0) @(posedge clk);

    issued = 0;
    while (issued < RANDOM_OPS) begin
      mode = $urandom_range(0, 9);
      fav  = $urandom_range(0, QUEUES - 1);
      calm = ($urandom_range(0, 5) == 0);
      if (mode < 4) begin
        len = $urandom_range(30, 90);
        for (int i = 0; i < len; i++) begin
          q = ($urandom_range(0, 3) != 0) ? fav : $urandom_range(0, QUEUES - 1);
          if ($urandom_range(0, 1) != 0) begin
            push_op = mqlf_pkg::OP_PUSH_FRONT;
          end else begin
            push_op = mqlf_pkg::OP_PUSH_REAR;
          end
          queue_op(push_op, q, pick_word(), calm);
        end
      end else if (mode < 7) begin
        len = $urandom_range(10, 60);
        for (int i = 0; i < len; i++) begin
          q = ($urandom_range(0, 3) != 0) ? fav : $urandom_range(0, QUEUES - 1);
          queue_op(mqlf_pkg::OP_POP, q, pick_word(), calm);
        end
      end else if (mode < 9) begin
        len = $urandom_range(10, 40);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 19);
          q = $urandom_range(0, QUEUES - 1);
          if (r < 7)       queue_op(mqlf_pkg::OP_PUSH_REAR,  q, pick_word(), calm);
          else if (r < 12) queue_op(mqlf_pkg::OP_PUSH_FRONT, q, pick_word(), calm);
          else if (r < 19) queue_op(mqlf_pkg::OP_POP,        q, pick_word(), calm);
          else             queue_op(mqlf_pkg::OP_CLEAR,      q, pick_word(), calm);
        end
      end else begin
        len = 0;
        for (int i = 0; i < QUEUES; i++) begin
          if ($urandom_range(0, 1)) begin
            queue_op(mqlf_pkg::OP_CLEAR, i, pick_word(), calm);
            len++;
          end
        end
      end
      issued += len;
    end

    while (op_backlog.size() > 0 || awaited_replies.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
